/* design/cos_pkg.sv */
package cos_pkg;

  localparam int PW    = 24;
  localparam int RW    = 16;
  localparam int IDXW  = 6;
  localparam int DVW   = 57;
  localparam int SQIW  = 52;
  localparam int SQOW  = 26;
  localparam int PROXW = 17;
  localparam int MAGW  = 32;
  localparam int CMW   = 26;

  localparam logic [1:0] CFG_PLAYER_X       = 2'd0;
  localparam logic [1:0] CFG_PLAYER_Y       = 2'd1;
  localparam logic [1:0] CFG_PLAYER_PRESENT = 2'd2;
  localparam logic [1:0] CFG_SPRITE_SIZE    = 2'd3;

  localparam logic [RW-1:0]    SPRITE_RESET = 16'd8192;
  localparam logic [PROXW-1:0] PROX_MIN     = 17'd13107;
  localparam logic [PROXW-1:0] PROX_MAX     = 17'd65536;
  localparam logic [CMW-1:0]   PUSH_LIMIT   = 26'd33554432;

  // x/5 by reciprocal: 32 bit x with a shift of 34, x < 2^18 with a shift of 20
  localparam logic [31:0]      RECIP_FIVE   = 32'hCCCCCCCD;
  localparam logic [17:0]      RECIP_FIVE_S = 18'd209716;
  // 2^17 = 5 * 26214 + 2
  localparam logic [14:0]      CAP_STEP     = 15'd26214;

  typedef logic signed [PW-1:0] pos_t;

  typedef struct packed {
    pos_t          x;
    pos_t          y;
    logic [RW-1:0] r;
  } body_t;

endpackage

/* design/circle_overlap_separation_top.sv */
// Bodies are taken one per cycle into a two-port body memory until one
// marked last arrives; no clearing pass is needed after reset. If a player is
// set, one pass then walks all pairs i<j in load order, reading and writing
// back the memory. An overlapping pair uses three square roots and up to
// three divisions through one shared root unit and one shared divider. The
// results then follow one body at a time, each read from the memory and then
// held on the output until it is transferred. No body is taken from the end
// of loading until the last result has been transferred.
module circle_overlap_separation_top import cos_pkg::*; #(
  parameter int MAX_BODIES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 body_valid,
  output logic                 body_stall,
  input  logic signed [PW-1:0] body_x,
  input  logic signed [PW-1:0] body_y,
  input  logic [RW-1:0]        radius,
  input  logic                 last_body,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [IDXW-1:0]      index,
  output logic signed [PW-1:0] new_x,
  output logic signed [PW-1:0] new_y,
  output logic                 last_result,
  output logic                 overflow,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [PW-1:0]        cfg_data
);

  localparam int AW = $clog2(MAX_BODIES);
  localparam int CW = $clog2(MAX_BODIES + 1);

  localparam logic [5:0] S_IDLE      = 6'd0;
  localparam logic [5:0] S_BEGIN     = 6'd1;
  localparam logic [5:0] S_RD_I      = 6'd2;
  localparam logic [5:0] S_RD_J      = 6'd3;
  localparam logic [5:0] S_CAP_J     = 6'd4;
  localparam logic [5:0] S_DIFF      = 6'd5;
  localparam logic [5:0] S_MSX       = 6'd6;
  localparam logic [5:0] S_MSY       = 6'd7;
  localparam logic [5:0] S_MT        = 6'd8;
  localparam logic [5:0] S_CMP       = 6'd9;
  localparam logic [5:0] S_SQ_WAIT   = 6'd10;
  localparam logic [5:0] S_PDIFF     = 6'd11;
  localparam logic [5:0] S_PMA       = 6'd12;
  localparam logic [5:0] S_PMB       = 6'd13;
  localparam logic [5:0] S_PSQ       = 6'd14;
  localparam logic [5:0] S_PSQ_WAIT  = 6'd15;
  localparam logic [5:0] S_PROX      = 6'd16;
  localparam logic [5:0] S_PROX_WAIT = 6'd17;
  localparam logic [5:0] S_PEN_MUL   = 6'd18;
  localparam logic [5:0] S_MAG_DIV   = 6'd19;
  localparam logic [5:0] S_MAG_WAIT  = 6'd20;
  localparam logic [5:0] S_CAP_DIV   = 6'd21;
  localparam logic [5:0] S_CAP_WAIT  = 6'd22;
  localparam logic [5:0] S_CX_MUL    = 6'd23;
  localparam logic [5:0] S_CX_DIV    = 6'd24;
  localparam logic [5:0] S_CX_WAIT   = 6'd25;
  localparam logic [5:0] S_CY_MUL    = 6'd26;
  localparam logic [5:0] S_CY_DIV    = 6'd27;
  localparam logic [5:0] S_CY_WAIT   = 6'd28;
  localparam logic [5:0] S_WR_I      = 6'd29;
  localparam logic [5:0] S_WR_J      = 6'd30;
  localparam logic [5:0] S_NEXT      = 6'd31;
  localparam logic [5:0] S_EM_RD     = 6'd32;
  localparam logic [5:0] S_EM_OUT    = 6'd33;

  localparam logic signed [PW+3:0] SAT_MAX = 28'sd8388607;
  localparam logic signed [PW+3:0] SAT_MIN = -28'sd8388608;

  function automatic logic [PW:0] abs_diff(input logic signed [PW-1:0] a,
                                           input logic signed [PW-1:0] b);
    logic signed [PW:0] d;
    d = {a[PW-1], a} - {b[PW-1], b};
    return d[PW] ? (PW+1)'(-d) : d;
  endfunction

  function automatic logic signed [PW-1:0] sat_pos(input logic signed [PW+3:0] v);
    if (v > SAT_MAX) return PW'(SAT_MAX);
    if (v < SAT_MIN) return PW'(SAT_MIN);
    return v[PW-1:0];
  endfunction

  logic [5:0]          state;
  logic [CW-1:0]       count;
  logic                ovf;
  logic [AW-1:0]       ii;
  logic [AW-1:0]       jj;
  logic [AW-1:0]       kk;

  logic signed [PW-1:0] player_x;
  logic signed [PW-1:0] player_y;
  logic                 player_present;
  logic [RW-1:0]        sprite_len;

  pos_t                xi, yi, xj, yj;
  logic [RW-1:0]       ri, rj;
  logic [PW:0]         ux, uy, pa, pb;
  logic                dxneg, dyneg;
  logic [RW:0]         target;
  logic [SQOW-1:0]     span, di;
  logic                pside;
  logic [49:0]         sqx, sqy;
  logic [DVW-1:0]      prod;
  logic [PROXW-1:0]    prox;
  logic [MAGW-1:0]     magq, mag;
  logic [CMW-1:0]      cxm, cym;
  logic [63:0]         rq;
  logic [30:0]         cpa;
  logic [34:0]         cpb;

  logic [PW:0]         mul_a;
  logic [MAGW-1:0]     mul_b;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  body_t               mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  body_t               mem_rdata;

  logic                sq_start;
  logic [SQIW-1:0]     sq_operand;
  logic                sq_busy;
  logic [SQOW-1:0]     sq_root;

  logic                div_start;
  logic [DVW-1:0]      div_num;
  logic [DVW-1:0]      div_den;
  logic                div_busy;
  logic [DVW-1:0]      div_quo;

  logic                body_take;
  logic                room;
  logic [SQIW-1:0]     d2x4;
  logic [SQOW-1:0]     dist_c;
  logic [SQOW-1:0]     maxd;
  logic [RW:0]         pen;
  logic [CMW-1:0]      cm_c;
  logic [30:0]         capv;
  logic signed [PW+3:0] xi_n, yi_n, xj_n, yj_n;

  assign cfg_ready  = 1'b1;
  assign body_stall = (state != S_IDLE);
  assign body_take  = body_valid && !body_stall;
  assign room       = (count < CW'(MAX_BODIES));

  assign d2x4   = {50'(sqx + sqy), 2'b00};
  assign dist_c = (sq_root == '0) ? SQOW'(1) : sq_root;
  assign maxd   = (di > sq_root) ? di : sq_root;
  assign pen    = target - (RW+1)'(span);
  assign cm_c   = (div_quo > DVW'(PUSH_LIMIT)) ? PUSH_LIMIT : div_quo[CMW-1:0];
  assign capv   = cpa + {16'd0, cpb[34:20]};

  assign xi_n = dxneg ? ({{4{xi[PW-1]}}, xi} + {2'b00, cxm})
                      : ({{4{xi[PW-1]}}, xi} - {2'b00, cxm});
  assign yi_n = dyneg ? ({{4{yi[PW-1]}}, yi} + {2'b00, cym})
                      : ({{4{yi[PW-1]}}, yi} - {2'b00, cym});
  assign xj_n = dxneg ? ({{4{xj[PW-1]}}, xj} - {2'b00, cxm})
                      : ({{4{xj[PW-1]}}, xj} + {2'b00, cxm});
  assign yj_n = dyneg ? ({{4{yj[PW-1]}}, yj} - {2'b00, cym})
                      : ({{4{yj[PW-1]}}, yj} + {2'b00, cym});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MSX:     begin mul_a = ux;             mul_b = MAGW'(ux);     end
      S_MSY:     begin mul_a = uy;             mul_b = MAGW'(uy);     end
      S_MT:      begin mul_a = (PW+1)'(target); mul_b = MAGW'(target); end
      S_PMA:     begin mul_a = pa;             mul_b = MAGW'(pa);     end
      S_PMB:     begin mul_a = pb;             mul_b = MAGW'(pb);     end
      S_PEN_MUL: begin mul_a = (PW+1)'(pen);   mul_b = MAGW'(prox);   end
      S_CX_MUL:  begin mul_a = ux;             mul_b = mag;           end
      S_CY_MUL:  begin mul_a = uy;             mul_b = mag;           end
      default:   begin mul_a = '0;             mul_b = '0;            end
    endcase
  end

  always_comb begin
    sq_start   = 1'b0;
    sq_operand = d2x4;
    if (state == S_CMP) begin
      sq_start = (DVW'(d2x4) < prod);
    end else if (state == S_PSQ) begin
      sq_start   = 1'b1;
      sq_operand = {50'(sqx + 50'(prod)), 2'b00};
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = prod;
    div_den   = DVW'({span, 17'd0});
    case (state)
      S_PROX: begin
        div_start = (sprite_len != '0);
        div_num   = DVW'({maxd, 16'd0});
        div_den   = DVW'({2'b00, sprite_len} + {1'b0, sprite_len, 1'b0});
      end
      S_CX_DIV, S_CY_DIV: begin
        div_start = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(count);
    mem_wdata = '{x: body_x, y: body_y, r: radius};
    mem_re    = 1'b0;
    mem_raddr = kk;
    case (state)
      S_IDLE: begin
        mem_we = body_take && room;
      end
      S_WR_I: begin
        mem_we    = 1'b1;
        mem_waddr = ii;
        mem_wdata = '{x: sat_pos(xi_n), y: sat_pos(yi_n), r: ri};
      end
      S_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = jj;
        mem_wdata = '{x: sat_pos(xj_n), y: sat_pos(yj_n), r: rj};
      end
      S_RD_I: begin
        mem_re    = 1'b1;
        mem_raddr = ii;
      end
      S_RD_J: begin
        mem_re    = 1'b1;
        mem_raddr = jj;
      end
      S_EM_RD: begin
        mem_re = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x       <= '0;
      player_y       <= '0;
      player_present <= 1'b0;
      sprite_len     <= SPRITE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PLAYER_X:       player_x       <= cfg_data;
        CFG_PLAYER_Y:       player_y       <= cfg_data;
        CFG_PLAYER_PRESENT: player_present <= cfg_data[0];
        CFG_SPRITE_SIZE:    sprite_len     <= cfg_data[RW-1:0];
        default:            player_present <= player_present;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ovf   <= 1'b0;
      ii    <= '0;
      jj    <= '0;
      kk    <= '0;
      pside <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (body_take) begin
            if (room) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (last_body) begin
              state <= S_BEGIN;
            end
          end
        end
        S_BEGIN: begin
          ii <= '0;
          jj <= AW'(1);
          kk <= '0;
          if (player_present && count >= CW'(2)) begin
            state <= S_RD_I;
          end else begin
            state <= S_EM_RD;
          end
        end
        S_RD_I:  state <= S_RD_J;
        S_RD_J:  state <= S_CAP_J;
        S_CAP_J: state <= S_DIFF;
        S_DIFF:  state <= S_MSX;
        S_MSX:   state <= S_MSY;
        S_MSY:   state <= S_MT;
        S_MT:    state <= S_CMP;
        S_CMP: begin
          state <= sq_start ? S_SQ_WAIT : S_NEXT;
        end
        S_SQ_WAIT: begin
          if (!sq_busy) begin
            if ((RW+1)'(0) == target || dist_c >= SQOW'(target)) begin
              state <= S_NEXT;
            end else begin
              pside <= 1'b0;
              state <= S_PDIFF;
            end
          end
        end
        S_PDIFF: state <= S_PMA;
        S_PMA:   state <= S_PMB;
        S_PMB:   state <= S_PSQ;
        S_PSQ:   state <= S_PSQ_WAIT;
        S_PSQ_WAIT: begin
          if (!sq_busy) begin
            if (!pside) begin
              pside <= 1'b1;
              state <= S_PDIFF;
            end else begin
              state <= S_PROX;
            end
          end
        end
        S_PROX: begin
          state <= (sprite_len != '0) ? S_PROX_WAIT : S_PEN_MUL;
        end
        S_PROX_WAIT: begin
          if (!div_busy) state <= S_PEN_MUL;
        end
        S_PEN_MUL:  state <= S_MAG_DIV;
        S_MAG_DIV:  state <= S_MAG_WAIT;
        S_MAG_WAIT: state <= S_CAP_DIV;
        S_CAP_DIV:  state <= S_CAP_WAIT;
        S_CAP_WAIT: state <= S_CX_MUL;
        S_CX_MUL: state <= S_CX_DIV;
        S_CX_DIV: state <= S_CX_WAIT;
        S_CX_WAIT: begin
          if (!div_busy) state <= S_CY_MUL;
        end
        S_CY_MUL: state <= S_CY_DIV;
        S_CY_DIV: state <= S_CY_WAIT;
        S_CY_WAIT: begin
          if (!div_busy) state <= S_WR_I;
        end
        S_WR_I: state <= S_WR_J;
        S_WR_J: state <= S_NEXT;
        S_NEXT: begin
          if (CW'(jj) + CW'(1) == count) begin
            if (CW'(ii) + CW'(2) >= count) begin
              state <= S_EM_RD;
            end else begin
              ii    <= ii + AW'(1);
              jj    <= AW'(CW'(ii) + CW'(2));
              state <= S_RD_I;
            end
          end else begin
            jj    <= jj + AW'(1);
            state <= S_RD_I;
          end
        end
        S_EM_RD: state <= S_EM_OUT;
        S_EM_OUT: begin
          if (!result_stall) begin
            if (last_result) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_IDLE;
            end else begin
              kk    <= kk + AW'(1);
              state <= S_EM_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= DVW'(mul_a * mul_b);
    case (state)
      S_RD_J: begin
        xi <= mem_rdata.x;
        yi <= mem_rdata.y;
        ri <= mem_rdata.r;
      end
      S_CAP_J: begin
        xj <= mem_rdata.x;
        yj <= mem_rdata.y;
        rj <= mem_rdata.r;
      end
      S_DIFF: begin
        ux     <= abs_diff(xj, xi);
        uy     <= abs_diff(yj, yi);
        dxneg  <= (xj < xi);
        dyneg  <= (yj < yi);
        target <= {1'b0, ri} + {1'b0, rj};
      end
      S_MSY, S_PMB: begin
        sqx <= prod[49:0];
      end
      S_MT: begin
        sqy <= prod[49:0];
      end
      S_SQ_WAIT: begin
        span <= dist_c;
      end
      S_PDIFF: begin
        pa <= pside ? abs_diff(xj, player_x) : abs_diff(xi, player_x);
        pb <= pside ? abs_diff(yj, player_y) : abs_diff(yi, player_y);
      end
      S_PSQ_WAIT: begin
        if (!pside) di <= sq_root;
      end
      S_PROX: begin
        prox <= PROX_MAX;
      end
      S_PROX_WAIT: begin
        if (div_quo < DVW'(PROX_MIN)) begin
          prox <= PROX_MIN;
        end else if (div_quo > DVW'(PROX_MAX)) begin
          prox <= PROX_MAX;
        end else begin
          prox <= div_quo[PROXW-1:0];
        end
      end
      S_MAG_DIV: begin
        // n / 10 as (n / 2) / 5
        rq <= {32'd0, prod[32:1]} * {32'd0, RECIP_FIVE};
      end
      S_MAG_WAIT: begin
        magq <= {2'b00, rq[63:34]};
      end
      S_CAP_DIV: begin
        cpa <= {15'd0, sprite_len} * {16'd0, CAP_STEP};
        cpb <= {18'd0, sprite_len, 1'b0} * {17'd0, RECIP_FIVE_S};
      end
      S_CAP_WAIT: begin
        mag <= (magq > {1'b0, capv}) ? {1'b0, capv} : magq;
      end
      S_CX_WAIT: begin
        cxm <= cm_c;
      end
      S_CY_WAIT: begin
        cym <= cm_c;
      end
      default: begin
        pa <= pa;
      end
    endcase
  end

  cos_mem #(
    .DEPTH (MAX_BODIES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cos_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (sq_operand),
    .busy    (sq_busy),
    .root    (sq_root)
  );

  cos_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign result_valid = (state == S_EM_OUT);
  assign index        = IDXW'(kk);
  assign new_x        = mem_rdata.x;
  assign new_y        = mem_rdata.y;
  assign last_result  = (CW'(kk) + CW'(1) == count);
  assign overflow     = ovf;

`ifndef ASSERT_OFF
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_sqrt_start_idle: assert property (@(posedge clk) disable iff (rst)
    sq_start |-> !sq_busy)
    else $error("root unit started while busy");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (CW'(kk) < count))
    else $error("result index beyond stored bodies");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_I) |-> (ii < jj && CW'(jj) < count))
    else $error("pair indices out of order");
`endif

endmodule

/* design/cos_mem.sv */
module cos_mem import cos_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  body_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output body_t         rdata
);

  body_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/cos_sqrt.sv */
module cos_sqrt import cos_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [SQIW-1:0] operand,
  output logic            busy,
  output logic [SQOW-1:0] root
);

  logic [SQIW-1:0] op;
  logic [SQOW+2:0] rem;
  logic [4:0]      cnt;
  logic [SQOW+2:0] rem_sh;
  logic [SQOW+2:0] trial;

  assign rem_sh = {rem[SQOW:0], op[SQIW-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'(SQOW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op   <= operand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      op <= {op[SQIW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[SQOW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[SQOW-2:0], 1'b0};
      end
    end
  end

endmodule

/* design/cos_div.sv */
module cos_div import cos_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DVW-1:0] num,
  input  logic [DVW-1:0] den,
  output logic           busy,
  output logic [DVW-1:0] quo
);

  logic [DVW-1:0] rem;
  logic [DVW-1:0] dreg;
  logic [5:0]     cnt;
  logic [DVW:0]   rem_sh;

  assign rem_sh = {rem, quo[DVW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'(DVW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= num;
      rem  <= '0;
      dreg <= den;
    end else if (busy) begin
      if (rem_sh >= {1'b0, dreg}) begin
        rem <= DVW'(rem_sh - {1'b0, dreg});
        quo <= {quo[DVW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DVW-1:0];
        quo <= {quo[DVW-2:0], 1'b0};
      end
    end
  end

endmodule

/* bench/tb_circle_overlap_separation_top.sv */
`timescale 1ns / 1ps

module tb_circle_overlap_separation_top;
  import cos_pkg::*;

  typedef struct {
    logic [IDXW-1:0] idx;
    pos_t            px;
    pos_t            py;
    logic            lst;
    logic            ovf;
  } body_pos_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic body_valid = 1'b0;
  logic body_stall;
  logic signed [PW-1:0] body_x = '0;
  logic signed [PW-1:0] body_y = '0;
  logic [RW-1:0] radius = '0;
  logic last_body = 1'b0;
  logic result_valid;
  logic result_stall = 1'b1;
  logic [IDXW-1:0] index;
  logic signed [PW-1:0] new_x;
  logic signed [PW-1:0] new_y;
  logic last_result;
  logic overflow;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [PW-1:0] cfg_data = '0;

  circle_overlap_separation_top uut (.*);

  // separation model state
  pos_t          mdl_x [64];
  pos_t          mdl_y [64];
  logic [RW-1:0] mdl_r [64];
  int            mdl_count = 0;
  bit            mdl_ovf = 0;
  pos_t          pl_x = '0;
  pos_t          pl_y = '0;
  bit            pl_present = 0;
  logic [RW-1:0] spr_size = SPRITE_RESET;

  body_pos_t expected_pos [$];
  int  err_count = 0;
  bit  quiet = 0;
  bit  hold_req = 0;
  int  hold_cnt = 0;
  int  wait_cnt = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #400_000_000;
    $display("tb_circle_overlap_separation_top: errors");
    $finish;
  end

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    err_count++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned uabs(input longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned dist_q9(input longint a, input longint b);
    return int_sqrt(4 * (uabs(a) * uabs(a) + uabs(b) * uabs(b)));
  endfunction

  function automatic pos_t sat_pos(input longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return pos_t'(v);
  endfunction

  function automatic longint axis_push(input longint d, input longint unsigned mag,
                                       input longint unsigned span);
    longint unsigned q;
    q = (uabs(d) * mag) / (span << 17);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic separate_bodies();
    longint dx, dy, cx, cy;
    longint unsigned d2, tgt, span, di, dj, maxd, prox, pen, mag, cap;
    for (int i = 0; i < mdl_count; i++) begin
      for (int j = i + 1; j < mdl_count; j++) begin
        dx = longint'(mdl_x[j]) - longint'(mdl_x[i]);
        dy = longint'(mdl_y[j]) - longint'(mdl_y[i]);
        d2 = 4 * (uabs(dx) * uabs(dx) + uabs(dy) * uabs(dy));
        tgt = longint'(mdl_r[i]) + longint'(mdl_r[j]);
        if (d2 >= tgt * tgt) continue;
        span = int_sqrt(d2);
        if (span < 1) span = 1;
        if (span >= tgt) continue;
        di = dist_q9(longint'(mdl_x[i]) - longint'(pl_x), longint'(mdl_y[i]) - longint'(pl_y));
        dj = dist_q9(longint'(mdl_x[j]) - longint'(pl_x), longint'(mdl_y[j]) - longint'(pl_y));
        maxd = (di > dj) ? di : dj;
        if (spr_size == 0) begin
          prox = 65536;
        end else begin
          prox = (maxd << 16) / (3 * longint'(spr_size));
          if (prox < 13107) prox = 13107;
          if (prox > 65536) prox = 65536;
        end
        pen = tgt - span;
        mag = (pen * prox) / 10;
        cap = (longint'(spr_size) << 17) / 5;
        if (mag > cap) mag = cap;
        cx = axis_push(dx, mag, span);
        cy = axis_push(dy, mag, span);
        mdl_x[i] = sat_pos(longint'(mdl_x[i]) - cx);
        mdl_y[i] = sat_pos(longint'(mdl_y[i]) - cy);
        mdl_x[j] = sat_pos(longint'(mdl_x[j]) + cx);
        mdl_y[j] = sat_pos(longint'(mdl_y[j]) + cy);
      end
    end
  endtask

  task automatic model_body(input pos_t x, input pos_t y, input logic [RW-1:0] r,
                            input logic lst);
    body_pos_t e;
    if (mdl_count < 64) begin
      mdl_x[mdl_count] = x;
      mdl_y[mdl_count] = y;
      mdl_r[mdl_count] = r;
      mdl_count++;
    end else begin
      mdl_ovf = 1;
    end
    if (lst) begin
      if (pl_present) separate_bodies();
      for (int k = 0; k < mdl_count; k++) begin
        e.idx = k[IDXW-1:0];
        e.px  = mdl_x[k];
        e.py  = mdl_y[k];
        e.lst = (k + 1 == mdl_count);
        e.ovf = mdl_ovf;
        expected_pos = {expected_pos, e};
      end
      mdl_count = 0;
      mdl_ovf = 0;
    end
  endtask

  // called at a falling edge; returns at a falling edge after the transfer
  task automatic send_body(input pos_t x, input pos_t y, input logic [RW-1:0] r,
                           input logic lst);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      body_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    body_x <= x;
    body_y <= y;
    radius <= r;
    last_body <= lst;
    body_valid <= 1'b1;
    do @(posedge clk); while (body_stall);
    model_body(x, y, r, lst);
    @(negedge clk);
  endtask

  task automatic drain();
    body_valid <= 1'b0;
    while (expected_pos.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PW-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PLAYER_X:       pl_x = pos_t'(data);
      CFG_PLAYER_Y:       pl_y = pos_t'(data);
      CFG_PLAYER_PRESENT: pl_present = data[0];
      CFG_SPRITE_SIZE:    spr_size = data[RW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_player(input pos_t x, input pos_t y, input bit on,
                            input logic [RW-1:0] ss);
    write_reg(CFG_PLAYER_X, x);
    write_reg(CFG_PLAYER_Y, y);
    write_reg(CFG_PLAYER_PRESENT, {23'd0, on});
    write_reg(CFG_SPRITE_SIZE, {8'd0, ss});
  endtask

  // clustered set around a centre so that pairs overlap
  task automatic send_cluster(input int n, input longint cx, input longint cy,
                              input int rmax);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(16, rmax);
      send_body(sat_pos(cx + $signed($urandom_range(0, 2 * r)) - r),
                sat_pos(cy + $signed($urandom_range(0, 2 * r)) - r),
                r[RW-1:0], k == n - 1);
    end
  endtask

  task automatic test_no_player();
    set_player(24'sh7FFFFF, 24'sh800000, 0, SPRITE_RESET);
    send_body(24'sh7FFFFF, 24'sh800000, 16'hFFFF, 0);
    send_body(24'sh800000, 24'sh7FFFFF, 16'h0000, 0);
    send_body(24'sh000000, 24'sh000000, 16'hFFFF, 1);
    send_body(24'sh000100, 24'sh000100, 16'h1000, 1);
    drain();
  endtask

  task automatic test_overlap_directed();
    set_player(24'sh000000, 24'sh000000, 1, SPRITE_RESET);
    send_body(24'sh000000, 24'sh000000, 16'h0800, 0);
    send_body(24'sh000000, 24'sh000000, 16'h0800, 0);
    send_body(24'sh000200, 24'shFFFF00, 16'h0800, 1);
    send_body(24'sh7FFF00, 24'sh7FFF00, 16'hFFFF, 0);
    send_body(24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 1);
    send_body(24'sh800000, 24'sh800010, 16'hFFFF, 0);
    send_body(24'sh800010, 24'sh800000, 16'hFFFF, 1);
    drain();
    set_player(24'sh001000, 24'shFFF000, 1, 16'd0);
    send_body(24'sh000000, 24'sh000000, 16'h0400, 0);
    send_body(24'sh000100, 24'sh000000, 16'h0400, 1);
    drain();
    set_player(24'sh100000, 24'sh100000, 1, 16'hFFFF);
    send_body(24'sh000000, 24'sh000000, 16'hFFFF, 0);
    send_body(24'sh004000, 24'sh002000, 16'hFFFF, 0);
    send_body(24'shFFC000, 24'sh001000, 16'h8000, 1);
    drain();
    set_player(24'sh000000, 24'sh000000, 1, 16'd1);
    send_body(24'sh000000, 24'sh000000, 16'h0200, 0);
    send_body(24'sh000080, 24'sh000040, 16'h0200, 1);
    drain();
  endtask

  task automatic test_full_store();
    set_player(24'sh000000, 24'sh000000, 0, SPRITE_RESET);
    for (int k = 0; k < 66; k++)
      send_body(pos_t'($urandom), pos_t'($urandom), RW'($urandom), k == 65);
    for (int k = 0; k < 64; k++)
      send_body(pos_t'(k * 24'h10000), pos_t'(k * 24'h10000), 16'h0100, k == 63);
    send_body(24'sh001234, 24'sh004321, 16'h0010, 1);
    drain();
    // full set with a player, spread wide so that no pair overlaps
    set_player(24'sh000000, 24'sh000000, 1, SPRITE_RESET);
    for (int k = 0; k < 64; k++)
      send_body(pos_t'((k - 32) * 24'h20000), pos_t'(k * 24'h1000), 16'h0100, k == 63);
    drain();
  endtask

  task automatic test_pressure();
    set_player(24'sh000000, 24'sh000000, 0, SPRITE_RESET);
    quiet = 1;
    hold_req = 1;
    for (int s = 0; s < 3; s++)
      for (int k = 0; k < 5; k++)
        send_body(pos_t'($urandom), pos_t'($urandom), RW'($urandom), k == 4);
    quiet = 0;
    drain();
  endtask

  task automatic test_random();
    int sent, n;
    longint cx, cy;
    sent = 0;
    while (sent < 80) begin
      if ($urandom_range(0, 7) == 0) begin
        drain();
        set_player(pos_t'($urandom_range(0, 60000) - 30000),
                   pos_t'($urandom_range(0, 60000) - 30000),
                   $urandom_range(0, 5) != 0,
                   ($urandom_range(0, 5) == 0) ? RW'($urandom) : RW'($urandom_range(256, 12000)));
      end
      quiet = ($urandom_range(0, 4) == 0);
      n = $urandom_range(1, 7);
      case ($urandom_range(0, 9))
        0: begin
          for (int k = 0; k < n; k++)
            send_body(pos_t'($urandom), pos_t'($urandom), RW'($urandom), k == n - 1);
        end
        1: begin
          cx = $urandom_range(0, 1) ? 8388000 : -8388000;
          send_cluster(n, cx, -cx, 4000);
        end
        default: begin
          cx = longint'(pl_x) + $signed($urandom_range(0, 40000)) - 20000;
          cy = longint'(pl_y) + $signed($urandom_range(0, 40000)) - 20000;
          send_cluster(n, cx, cy, 6000);
        end
      endcase
      sent += n;
    end
    quiet = 0;
    drain();
  endtask

  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      result_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req <= 0;
      hold_cnt <= 600;
      result_stall <= 1'b1;
    end else if (wait_cnt > 0) begin
      wait_cnt <= wait_cnt - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    body_pos_t e;
    if (!rst && result_valid && !result_stall) begin
      wait_cnt <= quiet ? 0 : $urandom_range(0, 18);
      if (expected_pos.size() == 0) begin
        report($sformatf("unexpected transfer index %0d", index));
      end else begin
        e = expected_pos.pop_front();
        if (index !== e.idx) report($sformatf("index %0d exp %0d", index, e.idx));
        if (new_x !== e.px)
          report($sformatf("idx %0d new_x %0d exp %0d", e.idx, new_x, e.px));
        if (new_y !== e.py)
          report($sformatf("idx %0d new_y %0d exp %0d", e.idx, new_y, e.py));
        if (last_result !== e.lst)
          report($sformatf("idx %0d last_result %b exp %b", e.idx, last_result, e.lst));
        if (overflow !== e.ovf)
          report($sformatf("idx %0d overflow %b exp %b", e.idx, overflow, e.ovf));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_no_player();
    test_overlap_directed();
    test_full_store();
    test_pressure();
    test_random();
    if (err_count == 0) begin
      $display("tb_circle_overlap_separation_top: clean");
    end else begin
      $display("tb_circle_overlap_separation_top: errors");
    end
    $finish;
  end

endmodule
